// ===== hdl/dpl_pkg.sv =====
// ----------------------------------------------------------------------------
// dpl_pkg: shared types and constants of the drive power limiter
// Fixed field widths, derived internal widths, class codes, register indexes.
// ----------------------------------------------------------------------------
package dpl_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int TQ_W        = 16;
    localparam int CFG_W       = 24;
    localparam int LIM_W       = 15;
    localparam int SCALE_W     = 17;
    localparam int IDX_W       = 3;
    localparam int SQ_W        = 31;
    localparam int SUM_W       = SQ_W + $clog2(WHEEL_COUNT);
    localparam int DEN_W       = CFG_W + SUM_W;
    localparam int STERM_W     = DEN_W - 8;
    localparam int USED_W      = STERM_W + 1;
    localparam int QUO_W       = 32;
    localparam int ROOT_W      = QUO_W / 2;
    localparam int REM_W       = ROOT_W + 2;

    localparam logic [SUM_W-1:0]   TORQUE_SQ_FLOOR = SUM_W'(16778);
    localparam logic [SCALE_W-1:0] SCALE_ONE       = SCALE_W'(65536);

    localparam logic [1:0] CLS_PASS   = 2'd0;
    localparam logic [1:0] CLS_ZERO   = 2'd1;
    localparam logic [1:0] CLS_DIVIDE = 2'd2;

    localparam logic [IDX_W-1:0] REG_POWER_BUDGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_TORQUE_COEFF = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPEED_COEFF  = 3'd2;
    localparam logic [IDX_W-1:0] REG_STATIC_LOSS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TORQUE_LIMIT = 3'd4;
    localparam logic [IDX_W-1:0] REG_MIN_SCALE    = 3'd5;

    typedef logic [WHEEL_COUNT-1:0][TQ_W-1:0] dpl_wheels_t;

    typedef struct packed {
        logic [CFG_W-1:0]   power_budget;
        logic [CFG_W-1:0]   torque_loss_coeff;
        logic [CFG_W-1:0]   speed_loss_coeff;
        logic [CFG_W-1:0]   static_loss;
        logic [LIM_W-1:0]   torque_limit;
        logic [SCALE_W-1:0] min_scale;
    } dpl_cfg_t;

    typedef struct packed {
        logic [1:0]       cls;
        logic             over;
        logic [CFG_W-1:0] num;
        logic [DEN_W-1:0] den;
        dpl_wheels_t      torque;
    } dpl_job_t;

endpackage

// ===== hdl/drive_power_limiter.sv =====
// ----------------------------------------------------------------------------
// drive_power_limiter: four-wheel torque limiter on a quadratic loss model
// Clamps torques, estimates power and scales torques to fit the budget.
// ----------------------------------------------------------------------------
// One wheel vector is accepted and one result leaves per clock cycle unless
// output back-pressure stalls. The front registers clamp, sum, loss products
// and budget compare in turn; jobs then pass the four-entry job queue and the
// back: the 32-stage restoring divider for the headroom ratio, then the 16-stage
// square root. Front and back stall independently: output back-pressure first
// fills the queue before input acceptance stops. The user must write
// configuration only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module drive_power_limiter
    import dpl_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [TQ_W-1:0]  torque_front_left,
    input  logic signed [TQ_W-1:0]  torque_front_right,
    input  logic signed [TQ_W-1:0]  torque_rear_left,
    input  logic signed [TQ_W-1:0]  torque_rear_right,
    input  logic signed [TQ_W-1:0]  speed_front_left,
    input  logic signed [TQ_W-1:0]  speed_front_right,
    input  logic signed [TQ_W-1:0]  speed_rear_left,
    input  logic signed [TQ_W-1:0]  speed_rear_right,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [TQ_W-1:0]  drive_front_left,
    output logic signed [TQ_W-1:0]  drive_front_right,
    output logic signed [TQ_W-1:0]  drive_rear_left,
    output logic signed [TQ_W-1:0]  drive_rear_right,
    output logic [SCALE_W-1:0]      torque_scale,
    output logic                    over_budget
);

    localparam int JOB_W = $bits(dpl_job_t);

    dpl_cfg_t    cfg_reg;
    dpl_wheels_t torque, speed, drive;
    dpl_job_t    push_job, pop_job;
    logic [JOB_W-1:0] pop_bits;
    logic        push_valid, push_ready, pop_valid, pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_budget      <= CFG_W'(3670016);
            cfg_reg.torque_loss_coeff <= CFG_W'(131072);
            cfg_reg.speed_loss_coeff  <= CFG_W'(655);
            cfg_reg.static_loss       <= CFG_W'(327680);
            cfg_reg.torque_limit      <= LIM_W'(12288);
            cfg_reg.min_scale         <= SCALE_W'(6554);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_POWER_BUDGET: cfg_reg.power_budget      <= cfg_data;
                REG_TORQUE_COEFF: cfg_reg.torque_loss_coeff <= cfg_data;
                REG_SPEED_COEFF:  cfg_reg.speed_loss_coeff  <= cfg_data;
                REG_STATIC_LOSS:  cfg_reg.static_loss       <= cfg_data;
                REG_TORQUE_LIMIT: cfg_reg.torque_limit      <= cfg_data[LIM_W-1:0];
                REG_MIN_SCALE:    cfg_reg.min_scale         <= cfg_data[SCALE_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign torque = {torque_rear_right, torque_rear_left,
                     torque_front_right, torque_front_left};
    assign speed  = {speed_rear_right, speed_rear_left,
                     speed_front_right, speed_front_left};

    dpl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .torque    (torque),
        .speed     (speed),
        .job_valid (push_valid),
        .job_ready (push_ready),
        .job       (push_job)
    );

    dpl_queue #(
        .WIDTH (JOB_W),
        .DEPTH (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_bits)
    );

    assign pop_job = dpl_job_t'(pop_bits);

    dpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .min_scale (cfg_reg.min_scale),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive),
        .scale     (torque_scale),
        .over      (over_budget)
    );

    assign drive_front_left  = drive[0];
    assign drive_front_right = drive[1];
    assign drive_rear_left   = drive[2];
    assign drive_rear_right  = drive[3];

    a_in_budget_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !over_budget |-> torque_scale == SCALE_ONE || torque_scale == '0)
        else $error("within-budget beat carries a partial scale");

    a_over_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && over_budget |-> torque_scale < SCALE_ONE)
        else $error("over-budget beat carries full scale");

    a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && torque_scale == '0 |-> drive_front_left == '0 && drive_rear_right == '0)
        else $error("zero scale with non-zero drive");

endmodule

// ===== hdl/dpl_front.sv =====
// ----------------------------------------------------------------------------
// dpl_front: clamp, power estimate and classification
// Four stages: clamp and square, sum, loss products, budget compare.
// ----------------------------------------------------------------------------
module dpl_front
    import dpl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dpl_cfg_t    cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  dpl_wheels_t torque,
    input  dpl_wheels_t speed,
    output logic        job_valid,
    input  logic        job_ready,
    output dpl_job_t    job
);

    logic [3:0] valid_reg;
    logic       en;

    dpl_wheels_t            s1_tq_reg, s2_tq_reg, s3_tq_reg;
    logic [SQ_W-1:0]        s1_tsq_reg [WHEEL_COUNT];
    logic [SQ_W-1:0]        s1_ssq_reg [WHEEL_COUNT];
    logic [SUM_W-1:0]       s2_ts_reg, s2_ss_reg;
    logic [DEN_W-1:0]       s3_den_reg;
    logic [STERM_W-1:0]     s3_sterm_reg;
    logic                   s3_small_reg;
    dpl_job_t               job_reg;

    dpl_wheels_t            tq_next;
    logic [SQ_W-1:0]        tsq_next [WHEEL_COUNT];
    logic [SQ_W-1:0]        ssq_next [WHEEL_COUNT];
    logic [SUM_W-1:0]       ts_next, ss_next;
    logic [DEN_W-1:0]       sprod;
    logic [USED_W-1:0]      used;
    logic [USED_W:0]        power;
    logic                   over;
    logic [1:0]             cls_next;

    assign en        = !(valid_reg[3] && !job_ready);
    assign in_ready  = en;
    assign job_valid = valid_reg[3];
    assign job       = job_reg;

    always_comb
    begin
        logic signed [TQ_W:0] lim;
        logic signed [TQ_W:0] t;
        logic signed [TQ_W:0] s;
        logic [TQ_W:0]        ta;
        logic [TQ_W:0]        sa;
        logic [2*TQ_W+1:0]    p;
        lim = $signed({2'b00, cfg.torque_limit});
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            t = $signed({torque[w][TQ_W-1], torque[w]});
            s = $signed({speed[w][TQ_W-1], speed[w]});
            if (t > lim)
                t = lim;
            if (t < -lim)
                t = -lim;
            tq_next[w] = t[TQ_W-1:0];
            ta = (t < 0) ? $unsigned(-t) : $unsigned(t);
            sa = (s < 0) ? $unsigned(-s) : $unsigned(s);
            p = ta * ta;
            tsq_next[w] = p[SQ_W-1:0];
            p = sa * sa;
            ssq_next[w] = p[SQ_W-1:0];
        end
    end

    always_comb
    begin
        ts_next = '0;
        ss_next = '0;
        for (int w = 0; w < WHEEL_COUNT; w++)
        begin
            ts_next = ts_next + SUM_W'(s1_tsq_reg[w]);
            ss_next = ss_next + SUM_W'(s1_ssq_reg[w]);
        end
    end

    assign sprod = cfg.speed_loss_coeff * s2_ss_reg;

    // power = k1*TS/2^24 + k2*SS/2^8 + k3, compared in full width
    assign used  = USED_W'(s3_sterm_reg) + USED_W'(cfg.static_loss);
    assign power = (USED_W+1)'(s3_den_reg[DEN_W-1:24]) + (USED_W+1)'(used);
    assign over  = power > (USED_W+1)'(cfg.power_budget);

    always_comb
    begin
        if (!over)
            cls_next = CLS_PASS;
        else if (s3_small_reg)
            cls_next = CLS_ZERO;
        else if (used >= USED_W'(cfg.power_budget) || s3_den_reg == '0)
            cls_next = CLS_ZERO;
        else
            cls_next = CLS_DIVIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tq_reg    <= tq_next;
            s1_tsq_reg   <= tsq_next;
            s1_ssq_reg   <= ssq_next;
            s2_tq_reg    <= s1_tq_reg;
            s2_ts_reg    <= ts_next;
            s2_ss_reg    <= ss_next;
            s3_tq_reg    <= s2_tq_reg;
            s3_den_reg   <= cfg.torque_loss_coeff * s2_ts_reg;
            s3_sterm_reg <= sprod[DEN_W-1:8];
            s3_small_reg <= s2_ts_reg < TORQUE_SQ_FLOOR;
            job_reg.torque <= s3_tq_reg;
            job_reg.den    <= s3_den_reg;
            job_reg.num    <= cfg.power_budget - used[CFG_W-1:0];
            job_reg.over   <= over;
            job_reg.cls    <= cls_next;
        end
    end

endmodule

// ===== hdl/dpl_queue.sv =====
// ----------------------------------------------------------------------------
// dpl_queue: short job queue between front and back
// Register FIFO; either side may stall without holding up the other.
// ----------------------------------------------------------------------------
module dpl_queue
    import dpl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [PTR_W:0]   count_reg;
    logic             push, pop;

    assign push_ready = count_reg != (PTR_W+1)'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTR_W'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

// ===== hdl/dpl_back.sv =====
// ----------------------------------------------------------------------------
// dpl_back: scale computation and torque scaling
// Load, 32 divider stages, 16 root stages, scale select, output multiply.
// ----------------------------------------------------------------------------
module dpl_back
    import dpl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SCALE_W-1:0] min_scale,
    input  logic               job_valid,
    output logic               job_ready,
    input  dpl_job_t           job,
    output logic               out_valid,
    input  logic               out_ready,
    output dpl_wheels_t        drive,
    output logic [SCALE_W-1:0] scale,
    output logic               over
);

    localparam int DIV_END  = QUO_W;
    localparam int SQ_END   = DIV_END + ROOT_W;
    localparam int SEL_ST   = SQ_END + 1;
    localparam int STAGES   = SEL_ST + 2;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [QUO_W-1:0]  bits;
    } sq_t;

    logic [STAGES-1:0]  valid_reg;
    logic               en;

    dpl_wheels_t        tq_reg   [STAGES-1];
    logic [1:0]         cls_reg  [STAGES-1];
    logic               over_reg [STAGES];
    logic [DEN_W-1:0]   den_reg  [DIV_END];
    logic [DEN_W-1:0]   r_reg    [DIV_END+1];
    logic [QUO_W-1:0]   q_reg    [DIV_END+1];
    sq_t                sq_reg   [ROOT_W];
    logic [SCALE_W-1:0] scale_reg [2];
    dpl_wheels_t        drive_reg;

    function automatic logic [DEN_W+QUO_W-1:0] div_step(
        input logic [DEN_W-1:0] r,
        input logic [QUO_W-1:0] q,
        input logic [DEN_W-1:0] d
    );
        logic [DEN_W:0] r2;
        logic [DEN_W:0] diff;
        r2   = {r, 1'b0};
        diff = r2 - {1'b0, d};
        if (r2 >= {1'b0, d})
            return {diff[DEN_W-1:0], q[QUO_W-2:0], 1'b1};
        else
            return {r2[DEN_W-1:0], q[QUO_W-2:0], 1'b0};
    endfunction

    function automatic sq_t sqrt_step(input sq_t s);
        logic [REM_W+1:0] rem4;
        logic [REM_W+1:0] trial;
        sq_t              o;
        rem4  = {s.rem, s.bits[QUO_W-1:QUO_W-2]};
        trial = (REM_W+2)'({s.root, 2'b01});
        o.bits = {s.bits[QUO_W-3:0], 2'b00};
        if (rem4 >= trial)
        begin
            rem4   = rem4 - trial;
            o.rem  = rem4[REM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = rem4[REM_W-1:0];
            o.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    assign en        = !(valid_reg[STAGES-1] && !out_ready);
    assign job_ready = en;
    assign out_valid = valid_reg[STAGES-1];
    assign drive     = drive_reg;
    assign scale     = scale_reg[1];
    assign over      = over_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[STAGES-2:0], job_valid};
    end

    always_ff @(posedge clk)
    begin
        logic [SCALE_W-1:0] sel;
        logic [TQ_W-1:0]    t;
        logic [TQ_W-1:0]    ta;
        logic [TQ_W+SCALE_W-1:0] prod;
        logic [TQ_W-1:0]    mag;
        if (en)
        begin
            tq_reg[0]   <= job.torque;
            cls_reg[0]  <= job.cls;
            over_reg[0] <= job.over;
            den_reg[0]  <= job.den;
            // start from num * 2^24, already below the divisor
            r_reg[0]    <= DEN_W'({job.num, 24'b0});
            q_reg[0]    <= '0;
            for (int k = 1; k < STAGES - 1; k++)
            begin
                tq_reg[k]  <= tq_reg[k-1];
                cls_reg[k] <= cls_reg[k-1];
            end
            for (int k = 1; k < STAGES; k++)
                over_reg[k] <= over_reg[k-1];
            for (int k = 1; k <= DIV_END; k++)
            begin
                if (k < DIV_END)
                    den_reg[k] <= den_reg[k-1];
                {r_reg[k], q_reg[k]}  <= div_step(r_reg[k-1], q_reg[k-1], den_reg[k-1]);
            end
            sq_reg[0] <= sqrt_step('{rem: '0, root: '0, bits: q_reg[DIV_END]});
            for (int k = 1; k < ROOT_W; k++)
                sq_reg[k] <= sqrt_step(sq_reg[k-1]);
            // select the applied scale
            unique case (cls_reg[SQ_END])
                CLS_PASS:   sel = SCALE_ONE;
                CLS_DIVIDE: sel = {1'b0, sq_reg[ROOT_W-1].root};
                default:    sel = '0;
            endcase
            if (sel < min_scale)
                sel = '0;
            scale_reg[0] <= sel;
            scale_reg[1] <= scale_reg[0];
            for (int w = 0; w < WHEEL_COUNT; w++)
            begin
                t    = tq_reg[SEL_ST][w];
                ta   = t[TQ_W-1] ? -t : t;
                prod = ta * scale_reg[0];
                mag  = prod[TQ_W+15:16];
                drive_reg[w] <= t[TQ_W-1] ? -mag : mag;
            end
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the drive power limiter
// Drives wheel vectors through several register settings with random gaps on
// both channels, predicts every result in a scoreboard and checks each beat.
// ----------------------------------------------------------------------------
module tb_top
    import dpl_pkg::*;
();

    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int               DRAIN_WAIT   = 120;
    localparam int               STALL_LIMIT  = 3000;
    localparam int               HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [WHEEL_COUNT-1:0][TQ_W-1:0] drive;
        logic [SCALE_W-1:0]               scale;
        logic                             over;
    } limit_result_t;

    class limiter_scoreboard;
        logic [63:0]   budget, k1, k2, k3, lim, min_sc;
        limit_result_t awaited[$];
        int            errors;
        int            checked;

        function new();
            budget = 3670016; k1 = 131072; k2 = 655; k3 = 327680;
            lim = 12288; min_sc = 6554;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_POWER_BUDGET: budget = val;
                REG_TORQUE_COEFF: k1 = val;
                REG_SPEED_COEFF:  k2 = val;
                REG_STATIC_LOSS:  k3 = val;
                REG_TORQUE_LIMIT: lim = val[LIM_W-1:0];
                REG_MIN_SCALE:    min_sc = val[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] res, trial;
            res = 0;
            for (int b = 31; b >= 0; b--)
            begin
                trial = res | (64'd1 << b);
                if (trial * trial <= v)
                    res = trial;
            end
            return res;
        endfunction

        // predict the result of one accepted wheel vector
        function void note_vector(logic [WHEEL_COUNT-1:0][TQ_W-1:0] tq,
                                  logic [WHEEL_COUNT-1:0][TQ_W-1:0] sp);
            int            t, s, lim_i;
            logic [63:0]   ta [WHEEL_COUNT];
            logic          neg [WHEEL_COUNT];
            logic [63:0]   ts, ss, tterm, sterm, power, used, den, num, scale, mag;
            logic [127:0]  quo;
            limit_result_t r;
            ts = 0; ss = 0;
            lim_i = int'(lim);
            for (int i = 0; i < WHEEL_COUNT; i++)
            begin
                t = int'($signed(tq[i]));
                s = int'($signed(sp[i]));
                if (t > lim_i) t = lim_i;
                if (t < -lim_i) t = -lim_i;
                neg[i] = (t < 0);
                ta[i] = (t < 0) ? 64'(-t) : 64'(t);
                ts += ta[i] * ta[i];
                ss += ((s < 0) ? 64'(-s) : 64'(s)) * ((s < 0) ? 64'(-s) : 64'(s));
            end
            tterm = (k1 * ts) >> 24;
            sterm = (k2 * ss) >> 8;
            power = tterm + sterm + k3;
            r.over = (power > budget);
            if (!r.over)
                scale = 65536;
            else if (ts < 16778)
                scale = 0;
            else
            begin
                used = sterm + k3;
                den  = k1 * ts;
                if (used >= budget || den == 0)
                    scale = 0;
                else
                begin
                    num = budget - used;
                    quo = ({64'd0, num} << 56) / {64'd0, den};
                    scale = root_floor(quo[63:0]);
                    if (scale > 65536)
                        scale = 65536;
                end
            end
            if (scale < min_sc)
                scale = 0;
            for (int i = 0; i < WHEEL_COUNT; i++)
            begin
                mag = (ta[i] * scale) >> 16;
                r.drive[i] = neg[i] ? TQ_W'(-mag) : TQ_W'(mag);
            end
            r.scale = scale[SCALE_W-1:0];
            awaited.push_back(r);
        endfunction

        function void report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch at beat %0d: %s got %0h want %0h", checked, what, got, want);
            errors++;
        endfunction

        function void check_result(limit_result_t got);
            limit_result_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch("unexpected beat", 0, 0);
                return;
            end
            want = awaited.pop_front();
            for (int i = 0; i < WHEEL_COUNT; i++)
                if (got.drive[i] !== want.drive[i])
                    report_mismatch($sformatf("drive[%0d]", i), got.drive[i], want.drive[i]);
            if (got.scale !== want.scale)
                report_mismatch("torque_scale", got.scale, want.scale);
            if (got.over !== want.over)
                report_mismatch("over_budget", got.over, want.over);
            checked++;
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [WHEEL_COUNT-1:0][TQ_W-1:0] tq_drv = '0;
    logic [WHEEL_COUNT-1:0][TQ_W-1:0] sp_drv = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [TQ_W-1:0] d_fl, d_fr, d_rl, d_rr;
    logic [SCALE_W-1:0] torque_scale;
    logic over_budget;

    logic no_idle = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   quiet_cycles = 0;
    int   sent = 0;
    limiter_scoreboard sb = new();

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    drive_power_limiter u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .torque_front_left(tq_drv[0]), .torque_front_right(tq_drv[1]),
        .torque_rear_left(tq_drv[2]), .torque_rear_right(tq_drv[3]),
        .speed_front_left(sp_drv[0]), .speed_front_right(sp_drv[1]),
        .speed_rear_left(sp_drv[2]), .speed_rear_right(sp_drv[3]),
        .out_valid(out_valid), .out_ready(out_ready),
        .drive_front_left(d_fl), .drive_front_right(d_fr),
        .drive_rear_left(d_rl), .drive_rear_right(d_rr),
        .torque_scale(torque_scale), .over_budget(over_budget)
    );

    // result monitor
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_result('{drive: {d_rr, d_rl, d_fr, d_fl}, scale: torque_scale,
                              over: over_budget});
    end

    // receiver: random stalls, one long hold on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done <= 1'b1;
                out_ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic load_regs(logic [CFG_W-1:0] b, logic [CFG_W-1:0] c1, logic [CFG_W-1:0] c2,
                             logic [CFG_W-1:0] c3, logic [CFG_W-1:0] l, logic [CFG_W-1:0] m);
        write_reg(REG_POWER_BUDGET, b);
        write_reg(REG_TORQUE_COEFF, c1);
        write_reg(REG_SPEED_COEFF, c2);
        write_reg(REG_STATIC_LOSS, c3);
        write_reg(REG_TORQUE_LIMIT, l);
        write_reg(REG_MIN_SCALE, m);
        // spare indexes must leave the registers alone
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_vector(logic [WHEEL_COUNT-1:0][TQ_W-1:0] tq,
                               logic [WHEEL_COUNT-1:0][TQ_W-1:0] sp);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        tq_drv   <= tq;
        sp_drv   <= sp;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_vector(tq, sp);
        sent++;
    endtask

    task automatic send_all(logic [TQ_W-1:0] t, logic [TQ_W-1:0] s);
        send_vector({4{t}}, {4{s}});
    endtask

    function automatic logic [TQ_W-1:0] pick_value(int mode, int span);
        case (mode)
            0: return TQ_W'($urandom);
            1: return TQ_W'($urandom_range(0, span) * ($urandom_range(0, 1) ? 1 : -1));
            default: return TQ_W'(($urandom_range(0, 1) ? 1 : -1) *
                                  (span + $urandom_range(0, 8) - 4));
        endcase
    endfunction

    task automatic random_vectors(int count);
        logic [WHEEL_COUNT-1:0][TQ_W-1:0] tq, sp;
        int tmode, smode;
        for (int n = 0; n < count; n++)
        begin
            tmode = $urandom_range(0, 2);
            smode = $urandom_range(0, 1);
            for (int i = 0; i < WHEEL_COUNT; i++)
            begin
                tq[i] = pick_value(tmode, (tmode == 1) ? $urandom_range(0, 20000)
                                                       : int'(sb.lim));
                sp[i] = pick_value(smode, $urandom_range(0, 3000));
            end
            send_vector(tq, sp);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and each limiting path at reset settings
        send_all(16'h7fff, 16'h7fff);
        send_all(16'h8000, 16'h8000);
        send_all(16'h0000, 16'h0000);
        send_all(16'hffff, 16'h0001);
        send_all(16'h0100, 16'h0010);
        send_all(16'h0040, 16'h7fff);
        send_all(16'h3000, 16'h0000);
        send_all(16'hd000, 16'h0400);
        send_all(16'h2000, 16'h0200);
        send_vector({16'h7fff, 16'h8000, 16'h0001, 16'hffff},
                    {16'h8000, 16'h7fff, 16'h0000, 16'h0100});
        send_all(16'h0010, 16'h0000);
        drain();

        load_regs(24'd3670016, 24'd131072, 24'd655, 24'd327680, 24'd0, 24'd6554);
        send_all(16'h7fff, 16'h0000);
        send_all(16'h8000, 16'h7fff);
        drain();
        load_regs(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'h7fff, 24'h1ffff);
        send_all(16'h7fff, 16'h0000);
        send_all(16'h0001, 16'h0001);
        send_all(16'h8000, 16'h8000);
        drain();
        load_regs(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        send_all(16'h7fff, 16'h7fff);
        send_all(16'h0000, 16'h0000);
        drain();
        load_regs(24'd1000, 24'd65536, 24'd0, 24'd0, 24'h7fff, 24'd65536);
        send_all(16'h4000, 16'h0000);
        send_all(16'h0010, 16'h0000);
        drain();

        // random phases; the first one runs into a long receiver hold
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: load_regs(24'd3670016, 24'd131072, 24'd655, 24'd327680,
                             24'd12288, 24'd6554);
                1: load_regs(24'hffffff, 24'd262144, 24'd100, 24'd0, 24'h7fff, 24'd0);
                2: load_regs(24'd0, 24'd131072, 24'd655, 24'd0, 24'd20000, 24'd65536);
                3: load_regs(24'd2000000, 24'hffffff, 24'd0, 24'hffffff, 24'd0, 24'd1000);
                default: load_regs(CFG_W'($urandom), CFG_W'($urandom_range(0, 1 << 20)),
                                   CFG_W'($urandom_range(0, 4000)),
                                   CFG_W'($urandom_range(0, 1 << 21)),
                                   CFG_W'($urandom_range(0, 32767)),
                                   CFG_W'($urandom_range(0, 70000)));
            endcase
            if (ph == 0)
                hold_req <= 1'b1;
            if (ph == 7)
                no_idle <= 1'b1;
            random_vectors(180);
            drain();
        end

        $display("%0d wheel vectors sent, %0d results checked, 13 register settings",
                 sent, sb.checked);
        $display("covered clamping, in-budget, tiny torque, no headroom and min scale cases");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
